FILE: rtl/scld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types and constants for the serial command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  // Line buffer sizing
  localparam int LINE_CAPACITY = 64;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);
  localparam int LEN_W         = 6;
  localparam int HEAD_DEPTH    = 6;

  // Baud argument accumulator
  localparam int                 BAUD_W      = 21;
  localparam int                 BAUD_PROD_W = BAUD_W + 4;
  localparam logic [BAUD_W-1:0]  BAUD_MAX    = 21'd2097151;
  localparam logic [BAUD_W-1:0]  BAUD_OK     = 21'd1000000;
  localparam int                 BAUD_POS    = 4;

  // Radio channel
  localparam int                 CHAN_W     = 5;
  localparam logic [CHAN_W-1:0]  CHAN_LOW   = 5'd11;
  localparam logic [CHAN_W-1:0]  CHAN_HIGH  = 5'd26;
  localparam logic [CHAN_W-1:0]  CHAN_RESET = 5'd20;
  localparam logic [CHAN_W-1:0]  CHAN_NONE  = 5'd0;

  // Characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_B     = "B";
  localparam logic [7:0] CH_C     = "C";
  localparam logic [7:0] CH_D     = "D";
  localparam logic [7:0] CH_I     = "I";
  localparam logic [7:0] CH_N     = "N";
  localparam logic [7:0] CH_O     = "O";
  localparam logic [7:0] CH_Q     = "Q";
  localparam logic [7:0] CH_R     = "R";
  localparam logic [7:0] CH_S     = "S";
  localparam logic [7:0] CH_T     = "T";

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_SET_CHAN   = 4'd1,
    CMD_BEACON_REQ = 4'd2,
    CMD_STOP       = 4'd3,
    CMD_INIT       = 4'd4,
    CMD_BAUD_OK    = 4'd5,
    CMD_BAUD_REJ   = 4'd6,
    CMD_START      = 4'd7,
    CMD_TEST       = 4'd8,
    CMD_SYNTAX_ERR = 4'd9
  } cmd_t;

  // View of the line after the current byte has been stored
  typedef struct packed {
    logic [HEAD_DEPTH-1:0][7:0] head;
    logic [BAUD_W-1:0]          baud;
    logic [LEN_W-1:0]           len;
    logic                       newline;
  } lc_view_t;

  // Decoded command and its side effects
  typedef struct packed {
    cmd_t              cmd;
    logic              chan_set;
    logic [CHAN_W-1:0] chan_val;
    logic              cap_set;
    logic              cap_clr;
    logic              ann_clr;
  } dec_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/scld_line_col.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scld_line_col
// Line collector: head bytes, stored count and baud digit accumulator.
// ----------------------------------------------------------------------------
module scld_line_col
  import scld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic [7:0] rx_byte,
  output lc_view_t        view
);

  logic [7:0]             head_r [HEAD_DEPTH];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [BAUD_W-1:0]      baud_r, baud_nxt;
  logic                   run_r, run_nxt;
  logic                   store;
  logic                   newline;
  logic [CNT_W-1:0]       count_upd;
  logic [BAUD_PROD_W-1:0] prod;

  assign store   = count_r < CNT_W'(LINE_CAPACITY - 1);
  assign newline = rx_byte == CH_NL;

  always_comb begin
    count_upd = store ? count_r + CNT_W'(1) : count_r;
    prod      = (BAUD_PROD_W'(baud_r) << 3) + (BAUD_PROD_W'(baud_r) << 1)
              + BAUD_PROD_W'(rx_byte[3:0]);
    baud_nxt  = baud_r;
    run_nxt   = run_r;
    if (store && (count_r >= CNT_W'(BAUD_POS)) && run_r) begin
      if (is_dec(rx_byte)) begin
        baud_nxt = (prod > BAUD_PROD_W'(BAUD_MAX)) ? BAUD_MAX : prod[BAUD_W-1:0];
      end else begin
        run_nxt = 1'b0;
      end
    end
    count_nxt = count_upd;
    if (newline) begin
      count_nxt = '0;
      baud_nxt  = '0;
      run_nxt   = 1'b1;
    end
  end

  // Head bytes as seen by the decoder, current byte included
  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      view.head[i] = (store && count_r == CNT_W'(i)) ? rx_byte : head_r[i];
    end
    // newline is never a digit, so the accumulator is already final
    view.baud    = baud_r;
    view.len     = LEN_W'(count_upd);
    view.newline = newline;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      if (adv && store && count_r == CNT_W'(i)) begin
        head_r[i] <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      baud_r  <= '0;
      run_r   <= 1'b1;
    end else if (adv) begin
      count_r <= count_nxt;
      baud_r  <= baud_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scld_cmd_dec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scld_cmd_dec
// Command decoder: matches the line head and extracts the channel argument.
// ----------------------------------------------------------------------------
module scld_cmd_dec
  import scld_pkg::*;
(
  input  lc_view_t view,
  output dec_t     dec
);

  logic [HEAD_DEPTH-1:0][7:0] h;
  logic                       is_c, is_brq, is_sto, is_ini, is_brd, is_sta, is_tst;
  logic                       arg3;
  logic [3:0]                 hi, lo;
  logic [6:0]                 val;
  logic                       in_range;

  assign h = view.head;

  always_comb begin
    is_c   = h[0] == CH_C && h[1] == CH_COLON && is_dec(h[2]) && is_dec(h[3]);
    is_brq = h[0] == CH_B && h[1] == CH_R && h[2] == CH_Q;
    is_sto = h[0] == CH_S && h[1] == CH_T && h[2] == CH_O;
    is_ini = h[0] == CH_I && h[1] == CH_N && h[2] == CH_I;
    is_brd = h[0] == CH_B && h[1] == CH_R && h[2] == CH_D && h[3] == CH_COLON;
    is_sta = h[0] == CH_S && h[1] == CH_T && h[2] == CH_A;
    is_tst = h[0] == CH_T && h[1] == CH_S && h[2] == CH_T;
    arg3   = h[3] == CH_COLON && is_dec(h[4]) && is_dec(h[5]);

    // two-digit argument: bytes 2,3 for C:, bytes 4,5 for INI:/STA:
    hi       = is_c ? h[2][3:0] : h[4][3:0];
    lo       = is_c ? h[3][3:0] : h[5][3:0];
    val      = (7'(hi) << 3) + (7'(hi) << 1) + 7'(lo);
    in_range = val >= 7'(CHAN_LOW) && val <= 7'(CHAN_HIGH);

    dec          = '0;
    dec.cmd      = CMD_SYNTAX_ERR;
    dec.chan_val = CHAN_W'(val);
    if (is_c) begin
      dec.cmd      = CMD_SET_CHAN;
      dec.chan_set = in_range;
      dec.ann_clr  = 1'b1;
    end else if (is_brq) begin
      dec.cmd = CMD_BEACON_REQ;
    end else if (is_sto) begin
      dec.cmd     = CMD_STOP;
      dec.cap_clr = 1'b1;
    end else if (is_ini) begin
      dec.cmd      = CMD_INIT;
      dec.chan_set = arg3 && in_range;
      dec.cap_set  = 1'b1;
      dec.ann_clr  = 1'b1;
    end else if (is_brd) begin
      dec.cmd = (view.baud == BAUD_OK) ? CMD_BAUD_OK : CMD_BAUD_REJ;
    end else if (is_sta) begin
      dec.cmd      = CMD_START;
      dec.chan_set = arg3 && in_range;
      dec.cap_set  = 1'b1;
      dec.ann_clr  = 1'b1;
    end else if (is_tst) begin
      dec.cmd = CMD_TEST;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/serial_command_line_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_line_decoder_unit
// Host serial command line decoder, one received byte per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one received byte; each produces exactly one result
// beat. Bytes are collected into a line (up to LINE_CAPACITY-1 stored, the
// rest dropped) and a newline decodes the line as C:nn, BRQ, STO, INI[:nn],
// BRD:digits, STA[:nn] or TST, anything else being a syntax error. The block
// sustains one beat per clock while results are drained: a byte sits in the
// input register, is decoded combinationally against the line state, and its
// result lands in the output register once that register is empty or being
// drained, which raises out_valid. The result register is the only place a
// stalled result waits; while it is held, a single further byte can be taken
// into the input register. No clearing pass runs after reset: the line head
// is read in full, so bytes past the end of a short line may be unset.
// ----------------------------------------------------------------------------
module serial_command_line_decoder_unit
  import scld_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // byte channel
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [7:0]        in_rx_byte,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              out_line_done,
  output      logic [3:0]        out_command,
  output      logic [CHAN_W-1:0] out_channel,
  output      logic              out_channel_changed,
  output      logic              out_capture_on,
  output      logic              out_announce_channel,
  output      logic [LEN_W-1:0]  out_line_length
);

  // input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             adv;

  // persistent radio state
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic [CHAN_W-1:0] ann_r, ann_nxt, ann_base;
  logic              cap_r, cap_nxt;
  logic              announce;
  logic              nl;

  // result register
  logic              out_valid_r;
  logic              out_done_r;
  cmd_t              out_cmd_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic              out_changed_r;
  logic              out_cap_r;
  logic              out_ann_r;
  logic [LEN_W-1:0]  out_len_r;

  lc_view_t view;
  dec_t     dec;

  // a byte advances when the result register is empty or being drained
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  scld_line_col u_line_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rx_byte (s1_byte_r),
    .view    (view)
  );

  scld_cmd_dec u_cmd_dec (
    .view (view),
    .dec  (dec)
  );

  assign nl = view.newline;

  // channel / capture / announcement update
  always_comb begin
    chan_nxt = (nl && dec.chan_set) ? dec.chan_val : chan_r;
    cap_nxt  = cap_r;
    if (nl && dec.cap_set) begin
      cap_nxt = 1'b1;
    end else if (nl && dec.cap_clr) begin
      cap_nxt = 1'b0;
    end
    ann_base = (nl && dec.ann_clr) ? CHAN_NONE : ann_r;
    announce = cap_nxt && (chan_nxt != ann_base);
    ann_nxt  = announce ? chan_nxt : ann_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= CHAN_RESET;
      ann_r       <= CHAN_NONE;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        chan_r <= chan_nxt;
        ann_r  <= ann_nxt;
        cap_r  <= cap_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_done_r    <= nl;
      out_cmd_r     <= nl ? dec.cmd : CMD_NONE;
      out_chan_r    <= chan_nxt;
      out_changed_r <= nl && dec.chan_set;
      out_cap_r     <= cap_nxt;
      out_ann_r     <= announce;
      out_len_r     <= nl ? view.len : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_line_done        = out_done_r;
  assign out_command          = out_cmd_r;
  assign out_channel          = out_chan_r;
  assign out_channel_changed  = out_changed_r;
  assign out_capture_on       = out_cap_r;
  assign out_announce_channel = out_ann_r;
  assign out_line_length      = out_len_r;

  // ---------------------------------------------------------------- checks
  a_done_has_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_cmd_r != CMD_NONE)
    else $error("finished line without a command");

  a_idle_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |->
      out_cmd_r == CMD_NONE && out_len_r == '0 && !out_changed_r)
    else $error("non-newline beat carries line fields");

  a_chan_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_chan_r >= CHAN_LOW && out_chan_r <= CHAN_HIGH)
    else $error("channel out of range");

  a_ann_needs_cap : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ann_r |-> out_cap_r)
    else $error("announcement without capture");

  a_ann_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    adv && announce |=> ann_r == chan_r)
    else $error("announced channel not updated");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives serial_command_line_decoder_unit with received bytes grouped into
// command lines and checks every result beat against a cycle-free model of
// the line decoder. A short table of hand-picked lines opens the run. Random
// lines follow: mostly well-formed commands with random arguments, plus
// broken keywords, noise and over-long lines. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import scld_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1700;
  localparam int IDLE_PCT     = 27;
  localparam int MAX_PRINTS   = 100;

  // One result beat as the decoder should present it
  typedef struct packed {
    logic              line_done;
    cmd_t              command;
    logic [CHAN_W-1:0] channel;
    logic              changed;
    logic              capture;
    logic              announce;
    logic [LEN_W-1:0]  length;
  } status_t;

  // Hand-typed expectation attached to one byte, used instead of the model
  typedef struct packed {
    logic    on;
    status_t val;
  } hint_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic              out_line_done;
  logic [3:0]        out_command;
  logic [CHAN_W-1:0] out_channel;
  logic              out_channel_changed;
  logic              out_capture_on;
  logic              out_announce_channel;
  logic [LEN_W-1:0]  out_line_length;

  serial_command_line_decoder_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_line_done       (out_line_done),
    .out_command         (out_command),
    .out_channel         (out_channel),
    .out_channel_changed (out_channel_changed),
    .out_capture_on      (out_capture_on),
    .out_announce_channel(out_announce_channel),
    .out_line_length     (out_line_length)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  int unsigned cycles = 0;
  always @(posedge clk) cycles <= cycles + 1;

  // --------------------------------------------------------------------------
  // Line decoder model: own copy of the line state, one call per byte
  // --------------------------------------------------------------------------
  logic [7:0]        head_m [HEAD_DEPTH];
  int unsigned       count_m   = 0;
  int unsigned       baud_m    = 0;
  bit                running_m = 1'b1;
  logic [CHAN_W-1:0] chan_m    = CHAN_RESET;
  logic [CHAN_W-1:0] ann_m     = CHAN_NONE;
  bit                cap_m     = 1'b0;

  initial foreach (head_m[i]) head_m[i] = 8'h00;

  function automatic bit digit_ok(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit head_is(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
    return head_m[0] == a && head_m[1] == b && head_m[2] == c;
  endfunction

  // Two digits at p, p+1; writes the channel when it lies in 11..26
  function automatic bit grab_channel(input int p);
    int unsigned v;
    v = (int'(head_m[p]) - int'(CH_ZERO)) * 10 + (int'(head_m[p+1]) - int'(CH_ZERO));
    if (v >= CHAN_LOW && v <= CHAN_HIGH) begin
      chan_m = v[CHAN_W-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ":dd" right after a three-letter keyword
  function automatic bit has_chan_arg();
    return head_m[3] == CH_COLON && digit_ok(head_m[4]) && digit_ok(head_m[5]);
  endfunction

  function automatic status_t decode_byte(input logic [7:0] c);
    status_t     r;
    int unsigned p;
    int unsigned v;
    r = '0;
    r.command = CMD_NONE;
    // store while there is room; the last slot is never filled
    if (count_m < LINE_CAPACITY - 1) begin
      p = count_m;
      if (p < HEAD_DEPTH) head_m[p] = c;
      if (p >= BAUD_POS && running_m) begin
        if (digit_ok(c)) begin
          v = baud_m * 10 + (int'(c) - int'(CH_ZERO));
          baud_m = (v > BAUD_MAX) ? BAUD_MAX : v;
        end else begin
          running_m = 1'b0;
        end
      end
      count_m = p + 1;
    end
    if (c == CH_NL) begin
      r.line_done = 1'b1;
      r.length    = count_m[LEN_W-1:0];
      if (head_m[0] == CH_C && head_m[1] == CH_COLON &&
          digit_ok(head_m[2]) && digit_ok(head_m[3])) begin
        r.command = CMD_SET_CHAN;
        r.changed = grab_channel(2);
        ann_m     = CHAN_NONE;
      end else if (head_is(CH_B, CH_R, CH_Q)) begin
        r.command = CMD_BEACON_REQ;
      end else if (head_is(CH_S, CH_T, CH_O)) begin
        r.command = CMD_STOP;
        cap_m     = 1'b0;
      end else if (head_is(CH_I, CH_N, CH_I)) begin
        r.command = CMD_INIT;
        if (has_chan_arg()) r.changed = grab_channel(4);
        cap_m = 1'b1;
        ann_m = CHAN_NONE;
      end else if (head_is(CH_B, CH_R, CH_D) && head_m[3] == CH_COLON) begin
        r.command = (baud_m == BAUD_OK) ? CMD_BAUD_OK : CMD_BAUD_REJ;
      end else if (head_is(CH_S, CH_T, CH_A)) begin
        r.command = CMD_START;
        if (has_chan_arg()) r.changed = grab_channel(4);
        cap_m = 1'b1;
        ann_m = CHAN_NONE;
      end else if (head_is(CH_T, CH_S, CH_T)) begin
        r.command = CMD_TEST;
      end else begin
        r.command = CMD_SYNTAX_ERR;
      end
      count_m   = 0;
      baud_m    = 0;
      running_m = 1'b1;
    end
    // announcement is due on every byte, not only at end of line
    if (cap_m && chan_m != ann_m) begin
      r.announce = 1'b1;
      ann_m      = chan_m;
    end
    r.channel = chan_m;
    r.capture = cap_m;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------
  status_t decoded_q [$];
  hint_t   hint_q [$];
  int      mismatches    = 0;
  int      lines_seen    = 0;
  int      chan_sets     = 0;
  int      baud_accepts  = 0;
  int      announcements = 0;
  int      overflows     = 0;

  // Run guard: a hung handshake or a lost beat ends here
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
    $display("testbench: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Input beats feed the model first, so a result landing in the same step
  // still finds its expectation queued.
  always @(posedge clk) begin
    status_t want;
    hint_t   h;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = decode_byte(in_rx_byte);
        h    = hint_q.pop_front();
        if (h.on) want = h.val;
        decoded_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = decoded_q.pop_front();
          check_field("line_done", 8'(out_line_done), 8'(want.line_done));
          check_field("command", 8'(out_command), 8'(want.command));
          check_field("channel", 8'(out_channel), 8'(want.channel));
          check_field("channel_changed", 8'(out_channel_changed), 8'(want.changed));
          check_field("capture_on", 8'(out_capture_on), 8'(want.capture));
          check_field("announce_channel", 8'(out_announce_channel), 8'(want.announce));
          check_field("line_length", 8'(out_line_length), 8'(want.length));
          if (want.line_done) lines_seen++;
          if (want.changed) chan_sets++;
          if (want.command == CMD_BAUD_OK) baud_accepts++;
          if (want.announce) announcements++;
          if (want.line_done && want.length == LINE_CAPACITY - 1) overflows++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stall generation
  // --------------------------------------------------------------------------
  bit gaps_on = 1'b1;

  // result side backpressure
  always @(posedge clk) out_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);

  int bytes_sent = 0;

  // One byte beat; valid stays up once raised until the handshake edge
  task automatic send_byte(input logic [7:0] b, input hint_t h);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    hint_q.push_back(h);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Line building
  // --------------------------------------------------------------------------
  logic [7:0] line_buf [$];

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Sends the line buffer; a typed expectation rides on its last byte
  task automatic send_line(input logic typed, input status_t want);
    hint_t h;
    for (int i = 0; i < line_buf.size(); i++) begin
      h.on  = typed && (i == line_buf.size() - 1);
      h.val = want;
      send_byte(line_buf[i], h);
    end
  endtask

  function automatic string keyword(input int k);
    case (k)
      0:       return "C:";
      1:       return "BRQ";
      2:       return "STO";
      3:       return "INI";
      4:       return "STA";
      5:       return "BRD:";
      default: return "TST";
    endcase
  endfunction

  // Mostly near the legal 11..26 window, sometimes any or a single digit
  task automatic add_chan_arg();
    if ($urandom_range(9) < 7) add_text($sformatf("%02d", $urandom_range(28, 9)));
    else if ($urandom_range(1) != 0) add_text($sformatf("%02d", $urandom_range(99)));
    else add_text($sformatf("%0d", $urandom_range(9)));
  endtask

  task automatic add_baud_arg();
    case ($urandom_range(5))
      0, 1: add_text("1000000");
      2:    add_text($sformatf("%0d", $urandom_range(1000003, 999997)));
      3:    add_text($sformatf("%0d", $urandom_range(3000000)));
      4:    add_text("0001000000");
      default: begin
        // long digit runs drive the accumulator into saturation
        repeat ($urandom_range(15, 8)) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
    endcase
  endtask

  task automatic build_random_line();
    int         pick;
    int         n;
    logic [7:0] b;
    line_buf.delete();
    pick = $urandom_range(99);
    if (pick < 12) begin
      add_text("C:");
      add_chan_arg();
    end else if (pick < 20) begin
      add_text("BRQ");
    end else if (pick < 28) begin
      add_text("STO");
    end else if (pick < 40) begin
      add_text("INI");
      if ($urandom_range(2) != 0) begin
        add_text(":");
        add_chan_arg();
      end
    end else if (pick < 52) begin
      add_text("STA");
      if ($urandom_range(2) != 0) begin
        add_text(":");
        add_chan_arg();
      end
    end else if (pick < 62) begin
      add_text("BRD:");
      add_baud_arg();
    end else if (pick < 68) begin
      add_text("TST");
    end else if (pick < 76) begin
      // broken keyword: cut short or one byte corrupted
      add_text(keyword($urandom_range(6)));
      if (line_buf.size() > 1 && $urandom_range(1) != 0) void'(line_buf.pop_back());
      else line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    end else if (pick < 86) begin
      repeat ($urandom_range(12)) line_buf.push_back(8'($urandom_range(255)));
    end else if (pick < 94) begin
      // long line, half of them right around the storage limit
      add_text(keyword($urandom_range(6)));
      n = ($urandom_range(1) != 0) ? $urandom_range(66, 58) : $urandom_range(90, 20);
      while (line_buf.size() < n) begin
        b = 8'($urandom_range(255));
        if (b == CH_NL) b = CH_ZERO;
        line_buf.push_back(b);
      end
    end
    // everything else stays an empty line
    if (pick < 68 && $urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom_range(255));
        if (b == CH_NL) b = CH_O;
        line_buf.push_back(b);
      end
    end
    line_buf.push_back(CH_NL);
  endtask

  // --------------------------------------------------------------------------
  // Directed table: text, then pad byte repeated, then newline
  // --------------------------------------------------------------------------
  string      row_text [$];
  logic [7:0] row_pad [$];
  int         row_pad_n [$];
  logic       row_typed [$];
  status_t    row_want [$];

  task automatic add_row(input string text, input logic [7:0] pad, input int pad_n);
    row_text.push_back(text);
    row_pad.push_back(pad);
    row_pad_n.push_back(pad_n);
    row_typed.push_back(1'b0);
    row_want.push_back('0);
  endtask

  task automatic add_typed(input string text, input logic [7:0] pad, input int pad_n,
                           input cmd_t cmd, input int chan,
                           input int chg, input int cap, input int ann,
                           input int len);
    status_t w;
    w.line_done = 1'b1;
    w.command   = cmd;
    w.channel   = CHAN_W'(chan);
    w.changed   = 1'(chg);
    w.capture   = 1'(cap);
    w.announce  = 1'(ann);
    w.length    = LEN_W'(len);
    row_text.push_back(text);
    row_pad.push_back(pad);
    row_pad_n.push_back(pad_n);
    row_typed.push_back(1'b1);
    row_want.push_back(w);
  endtask

  initial begin
    int i;
    int rand_start;
    int k;

    //        text            pad    n   command         ch  chg cap ann len
    add_typed("",             8'h00, 0,  CMD_SYNTAX_ERR, 20, 0,  0,  0,  1);  // lone newline
    add_typed("",             8'h00, 2,  CMD_SYNTAX_ERR, 20, 0,  0,  0,  3);  // zero bytes
    add_typed("BRQ",          8'h00, 0,  CMD_BEACON_REQ, 20, 0,  0,  0,  4);
    add_typed("C:11",         8'h00, 0,  CMD_SET_CHAN,   11, 1,  0,  0,  5);  // low edge
    add_typed("C:27",         8'h00, 0,  CMD_SET_CHAN,   11, 0,  0,  0,  5);  // out of range
    add_typed("INI",          8'h00, 0,  CMD_INIT,       11, 0,  1,  1,  4);
    add_typed("STA:26",       8'h00, 0,  CMD_START,      26, 1,  1,  1,  7);  // high edge
    add_typed("C:26",         8'h00, 0,  CMD_SET_CHAN,   26, 1,  1,  1,  5);  // same channel
    add_typed("INI:10",       8'h00, 0,  CMD_INIT,       26, 0,  1,  1,  7);
    add_typed("TST",          8'h00, 0,  CMD_TEST,       26, 0,  1,  0,  4);
    add_typed("STO",          8'h00, 0,  CMD_STOP,       26, 0,  0,  0,  4);
    add_typed("STA",          8'h00, 0,  CMD_START,      26, 0,  1,  1,  4);
    add_typed("BRD:1000000",  8'h00, 0,  CMD_BAUD_OK,    26, 0,  1,  0,  12);
    add_typed("BRD:999999",   8'h00, 0,  CMD_BAUD_REJ,   26, 0,  1,  0,  11);
    add_row  ("BRD:",         "9",   9);                                      // saturation
    add_row  ("BRD:1000000x5", 8'h00, 0);                                     // digits stop
    add_typed("C:1",          8'h00, 0,  CMD_SYNTAX_ERR, 26, 0,  1,  0,  4);
    add_row  ("STX",          8'h00, 0);
    add_typed("TST",          8'hFF, 70, CMD_TEST,       26, 0,  1,  0,  63); // overflow
    add_row  ("INI:2",        8'h00, 0);
    add_row  ("C:19",         8'h00, 0);
    add_row  ("STO",          8'h00, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < row_text.size(); i++) begin
      line_buf.delete();
      add_text(row_text[i]);
      repeat (row_pad_n[i]) line_buf.push_back(row_pad[i]);
      line_buf.push_back(CH_NL);
      send_line(row_typed[i], row_want[i]);
    end

    // random lines; one long window runs with no stalls on either side
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      k       = bytes_sent - rand_start;
      gaps_on = (k < 700 || k >= 1100);
      build_random_line();
      send_line(1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then wait on for any stray beat
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d cycles: %0d lines, %0d channel writes, %0d baud accepts",
             bytes_sent, cycles, lines_seen, chan_sets, baud_accepts);
    $display("%0d announcements, %0d full-length lines, %0d mismatches",
             announcements, overflows, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
